/* rtl/rcpfa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcpfa_pkg: shared types, constants and microcode for the page frame allocator
// Holds the control word layout, the step program and the result encodings.
// ----------------------------------------------------------------------------
package rcpfa_pkg;

	// defaults for the top level parameters
	localparam int          FRAME_COUNT_DEF     = 16384;
	localparam int          RESERVED_FRAMES_DEF = 896;
	localparam logic [31:0] MEMORY_BASE_DEF     = 32'h0010_0000;

	// entry word layout and fixed values
	localparam logic [31:0] ADDR_MASK      = 32'hffff_f000;
	localparam logic [31:0] WRITE_BIT      = 32'h0000_0002;
	localparam logic [31:0] NEW_FLAGS      = 32'h0000_0007;
	localparam logic [7:0]  RESERVED_COUNT = 8'd100;
	localparam logic [7:0]  COUNT_MAX      = 8'hff;
	localparam int          PAGE_SHIFT     = 12;

	// action codes
	localparam logic [1:0] ACT_ALLOC  = 2'd0;
	localparam logic [1:0] ACT_SHARE  = 2'd1;
	localparam logic [1:0] ACT_WFAULT = 2'd2;

	// step counter and program addresses
	typedef logic [4:0] step_t;

	localparam step_t P_IDLE     = 5'd0;
	localparam step_t P_A_INIT   = 5'd1;
	localparam step_t P_A_SCAN   = 5'd2;
	localparam step_t P_A_FAIL   = 5'd3;
	localparam step_t P_A_TAKE   = 5'd4;
	localparam step_t P_S_CHK    = 5'd5;
	localparam step_t P_S_INC    = 5'd6;
	localparam step_t P_S_SKIP   = 5'd7;
	localparam step_t P_W_CHK    = 5'd8;
	localparam step_t P_W_ONE    = 5'd9;
	localparam step_t P_W_INIT   = 5'd10;
	localparam step_t P_W_SCAN   = 5'd11;
	localparam step_t P_W_FAIL   = 5'd12;
	localparam step_t P_W_TAKE   = 5'd13;
	localparam step_t P_W_READ   = 5'd14;
	localparam step_t P_W_DEC    = 5'd15;
	localparam step_t P_W_NEW    = 5'd16;
	localparam step_t P_W_OWN    = 5'd17;
	localparam step_t P_NOP      = 5'd18;

	// branch conditions
	typedef enum logic [1:0] {
		COND_NONE   = 2'd0,
		COND_HIT    = 2'd1,
		COND_NOT_OK = 2'd2,
		COND_ONE    = 2'd3
	} cond_t;

	// count store write kinds
	typedef enum logic [1:0] {
		WR_NONE = 2'd0,
		WR_ONE  = 2'd1,
		WR_INC  = 2'd2,
		WR_DEC  = 2'd3
	} wr_t;

	// result selection
	typedef enum logic [2:0] {
		RES_ZERO       = 3'd0,
		RES_ALLOC      = 3'd1,
		RES_ALLOC_FAIL = 3'd2,
		RES_SHARE      = 3'd3,
		RES_WF_OWN     = 3'd4,
		RES_WF_NEW     = 3'd5,
		RES_WF_FAIL    = 3'd6
	} res_t;

	// one control word per step
	typedef struct packed {
		logic  scan_init;
		logic  scan_run;
		logic  loop;
		logic  rd_idx;
		wr_t   wr;
		res_t  res;
		logic  emit;
		cond_t cond;
		step_t target;
	} cw_t;

	// status from the datapath back to the sequencer
	typedef struct packed {
		logic hit;
		logic scan_end;
		logic ok;
		logic one;
		logic out_room;
	} st_t;

	localparam cw_t CW_NOP = '{
		scan_init: 1'b0, scan_run: 1'b0, loop: 1'b0, rd_idx: 1'b0,
		wr: WR_NONE, res: RES_ZERO, emit: 1'b0, cond: COND_NONE, target: P_IDLE
	};

	// microcode rom
	function automatic cw_t ucode(input step_t pc);
		cw_t w;
		w = CW_NOP;
		case (pc)
			P_A_INIT: begin
				w.scan_init = 1'b1;
			end
			P_A_SCAN: begin
				w.scan_run = 1'b1;
				w.loop     = 1'b1;
				w.cond     = COND_HIT;
				w.target   = P_A_TAKE;
			end
			P_A_FAIL: begin
				w.res  = RES_ALLOC_FAIL;
				w.emit = 1'b1;
			end
			P_A_TAKE: begin
				w.wr   = WR_ONE;
				w.res  = RES_ALLOC;
				w.emit = 1'b1;
			end
			P_S_CHK: begin
				w.rd_idx = 1'b1;
				w.cond   = COND_NOT_OK;
				w.target = P_S_SKIP;
			end
			P_S_INC: begin
				w.wr   = WR_INC;
				w.res  = RES_SHARE;
				w.emit = 1'b1;
			end
			P_S_SKIP: begin
				w.res  = RES_SHARE;
				w.emit = 1'b1;
			end
			P_W_CHK: begin
				w.rd_idx = 1'b1;
				w.cond   = COND_NOT_OK;
				w.target = P_W_INIT;
			end
			P_W_ONE: begin
				w.cond   = COND_ONE;
				w.target = P_W_OWN;
			end
			P_W_INIT: begin
				w.scan_init = 1'b1;
			end
			P_W_SCAN: begin
				w.scan_run = 1'b1;
				w.loop     = 1'b1;
				w.cond     = COND_HIT;
				w.target   = P_W_TAKE;
			end
			P_W_FAIL: begin
				w.res  = RES_WF_FAIL;
				w.emit = 1'b1;
			end
			P_W_TAKE: begin
				w.wr     = WR_ONE;
				w.cond   = COND_NOT_OK;
				w.target = P_W_NEW;
			end
			P_W_READ: begin
				w.rd_idx = 1'b1;
			end
			P_W_DEC: begin
				w.wr   = WR_DEC;
				w.res  = RES_WF_NEW;
				w.emit = 1'b1;
			end
			P_W_NEW: begin
				w.res  = RES_WF_NEW;
				w.emit = 1'b1;
			end
			P_W_OWN: begin
				w.res  = RES_WF_OWN;
				w.emit = 1'b1;
			end
			P_NOP: begin
				w.res  = RES_ZERO;
				w.emit = 1'b1;
			end
			default: begin
				w = CW_NOP;
			end
		endcase
		return w;
	endfunction

	// first step of each action
	function automatic step_t entry_step(input logic [1:0] act);
		step_t s;
		case (act)
			ACT_ALLOC:  s = P_A_INIT;
			ACT_SHARE:  s = P_S_CHK;
			ACT_WFAULT: s = P_W_CHK;
			default:    s = P_NOP;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

/* rtl/rcpfa_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcpfa_mem: reference count store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rcpfa_mem #(
	parameter int FRAME_COUNT = rcpfa_pkg::FRAME_COUNT_DEF,
	parameter int IW          = $clog2(FRAME_COUNT)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [IW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [IW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] count_q [FRAME_COUNT];
	logic [7:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			count_q[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= count_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* rtl/rcpfa_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcpfa_seq: microcode sequencer
// Step counter, control rom lookup, dispatch on action and conditional jumps.
// ----------------------------------------------------------------------------
module rcpfa_seq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           clearing,
	input  wire logic           in_valid,
	input  wire logic [1:0]     action,
	input  wire rcpfa_pkg::st_t st,
	output logic                in_stall,
	output logic                accept,
	output logic                go,
	output rcpfa_pkg::cw_t      cw
);

	import rcpfa_pkg::*;

	step_t pc_q;
	logic  cond_true;

	assign cw       = ucode(pc_q);
	assign in_stall = clearing || (pc_q != P_IDLE);
	assign accept   = in_valid && !in_stall;

	// an emitting step waits for room in the output register
	assign go = !(cw.emit && !st.out_room);

	// branch condition select
	always_comb begin
		case (cw.cond)
			COND_HIT:    cond_true = st.hit;
			COND_NOT_OK: cond_true = !st.ok;
			COND_ONE:    cond_true = st.one;
			default:     cond_true = 1'b0;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= P_IDLE;
		end else if (pc_q == P_IDLE) begin
			if (accept) begin
				pc_q <= entry_step(action);
			end
		end else if (go) begin
			if (cw.emit) begin
				pc_q <= P_IDLE;
			end else if (cond_true) begin
				pc_q <= cw.target;
			end else if (cw.loop && !st.scan_end) begin
				pc_q <= pc_q;
			end else begin
				pc_q <= pc_q + step_t'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/rcpfa_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcpfa_dp: allocator datapath
// Item registers, frame index check, downward scan, count update and
// the output register.
// ----------------------------------------------------------------------------
module rcpfa_dp #(
	parameter int          FRAME_COUNT = rcpfa_pkg::FRAME_COUNT_DEF,
	parameter logic [31:0] MEMORY_BASE = rcpfa_pkg::MEMORY_BASE_DEF,
	parameter int          IW          = $clog2(FRAME_COUNT)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire logic           go,
	input  wire rcpfa_pkg::cw_t cw,
	input  wire logic [1:0]     action,
	input  wire logic [31:0]    entry,
	input  wire logic [7:0]     mem_rdata,
	input  wire logic           out_stall,
	output rcpfa_pkg::st_t      st,
	output logic                mem_we,
	output logic [IW-1:0]       mem_waddr,
	output logic [7:0]          mem_wdata,
	output logic                mem_re,
	output logic [IW-1:0]       mem_raddr,
	output logic                out_valid,
	output logic [31:0]         result_word,
	output logic                copy_needed,
	output logic                out_of_frames
);

	import rcpfa_pkg::*;

	logic [31:0]   entry_q;
	logic [IW-1:0] idx_q;
	logic          ok_q;
	logic [IW-1:0] scan_q;
	logic          scan_live_q;
	logic [IW-1:0] raddr_s1;
	logic          rvalid_s1;
	logic          out_valid_q;
	logic [31:0]   word_q;
	logic          copy_q;
	logic          none_q;

	logic [31:0] probe;
	logic [31:0] diff;
	logic [19:0] off;
	logic        in_range;
	logic        above;
	logic        issue;
	logic [31:0] fresh_addr;
	logic [31:0] res_word;
	logic        res_copy;
	logic        res_none;
	logic        out_load;

	// frame index of the incoming entry
	always_comb begin
		if (action == ACT_SHARE) begin
			probe = entry & ~WRITE_BIT;
			above = probe > MEMORY_BASE;
		end else begin
			probe = entry & ADDR_MASK;
			above = probe >= MEMORY_BASE;
		end
		diff     = probe - MEMORY_BASE;
		off      = diff[31:PAGE_SHIFT];
		in_range = {1'b0, off} < 21'(FRAME_COUNT);
	end

	// item registers
	always_ff @(posedge clk) begin
		if (accept) begin
			entry_q <= entry;
			idx_q   <= off[IW-1:0];
			ok_q    <= above && in_range;
		end
	end

	// downward scan, one read issued per cycle; stops on a free frame so
	// that its index stays in raddr_s1
	assign issue = cw.scan_run && scan_live_q && !st.hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_live_q <= 1'b0;
			rvalid_s1   <= 1'b0;
		end else begin
			rvalid_s1 <= issue;
			if (cw.scan_init) begin
				scan_live_q <= 1'b1;
			end else if (issue && (scan_q == '0)) begin
				scan_live_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cw.scan_init) begin
			scan_q <= IW'(FRAME_COUNT - 1);
		end else if (issue) begin
			scan_q <= scan_q - IW'(1);
		end
		if (issue) begin
			raddr_s1 <= scan_q;
		end
	end

	// count store access
	assign mem_re    = issue || cw.rd_idx;
	assign mem_raddr = issue ? scan_q : idx_q;
	assign mem_we    = go && (cw.wr != WR_NONE);
	assign mem_waddr = (cw.wr == WR_ONE) ? raddr_s1 : idx_q;

	always_comb begin
		case (cw.wr)
			WR_ONE:  mem_wdata = 8'd1;
			WR_INC:  mem_wdata = mem_rdata + {7'd0, mem_rdata != COUNT_MAX};
			WR_DEC:  mem_wdata = mem_rdata - {7'd0, mem_rdata != 8'd0};
			default: mem_wdata = mem_rdata;
		endcase
	end

	// status to the sequencer
	assign st.hit      = rvalid_s1 && (mem_rdata == 8'd0);
	assign st.scan_end = rvalid_s1 && (raddr_s1 == '0);
	assign st.ok       = ok_q;
	assign st.one      = mem_rdata == 8'd1;
	assign st.out_room = !out_valid_q || !out_stall;

	// result select
	assign fresh_addr = MEMORY_BASE + (32'(raddr_s1) << PAGE_SHIFT);

	always_comb begin
		res_word = 32'd0;
		res_copy = 1'b0;
		res_none = 1'b0;
		case (cw.res)
			RES_ALLOC:      res_word = fresh_addr;
			RES_ALLOC_FAIL: res_none = 1'b1;
			RES_SHARE:      res_word = entry_q & ~WRITE_BIT;
			RES_WF_OWN:     res_word = entry_q | WRITE_BIT;
			RES_WF_NEW: begin
				res_word = fresh_addr | NEW_FLAGS;
				res_copy = 1'b1;
			end
			RES_WF_FAIL: begin
				res_word = entry_q;
				res_none = 1'b1;
			end
			default: res_word = 32'd0;
		endcase
	end

	// output register
	assign out_load = cw.emit && go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			word_q <= res_word;
			copy_q <= res_copy;
			none_q <= res_none;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_word   = word_q;
	assign copy_needed   = copy_q;
	assign out_of_frames = none_q;

endmodule
`default_nettype wire

/* rtl/refcounted_page_frame_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator: copy-on-write page frame allocator
// Keeps an 8-bit reference count per frame; allocates, shares and resolves
// write faults under a microcoded sequencer.
//
//   channel  signals                                     direction
//   in       in_valid, in_stall, action, entry           into the block
//   out      out_valid, out_stall, result_word,
//            copy_needed, out_of_frames                  out of the block
//
// after reset a clearing pass fills the count store (reserved frames 100,
// the rest 0); in_stall stays high during it. allocate and write fault
// with a new frame scan the store from the top, one read a cycle.
// one item at a time; a finished transfer waits in the output register
// while the next item is taken.
// ----------------------------------------------------------------------------
module refcounted_page_frame_allocator #(
	parameter int          FRAME_COUNT     = rcpfa_pkg::FRAME_COUNT_DEF,
	parameter int          RESERVED_FRAMES = rcpfa_pkg::RESERVED_FRAMES_DEF,
	parameter logic [31:0] MEMORY_BASE     = rcpfa_pkg::MEMORY_BASE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [31:0] entry,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      result_word,
	output logic             copy_needed,
	output logic             out_of_frames
);

	import rcpfa_pkg::*;

	localparam int IW = $clog2(FRAME_COUNT);

	logic          clearing_q;
	logic [IW-1:0] clr_q;
	logic [7:0]    clr_val;

	cw_t           cw;
	st_t           st;
	logic          accept;
	logic          go;

	logic          dp_we;
	logic [IW-1:0] dp_waddr;
	logic [7:0]    dp_wdata;
	logic          mem_re;
	logic [IW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			if (clr_q == IW'(FRAME_COUNT - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_q <= clr_q + IW'(1);
			end
		end
	end

	assign clr_val = (32'(clr_q) < 32'(RESERVED_FRAMES)) ? RESERVED_COUNT : 8'd0;

	// write port shared by the clearing pass and the datapath
	assign mem_we    = clearing_q || dp_we;
	assign mem_waddr = clearing_q ? clr_q : dp_waddr;
	assign mem_wdata = clearing_q ? clr_val : dp_wdata;

	rcpfa_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.clearing (clearing_q),
		.in_valid (in_valid),
		.action   (action),
		.st       (st),
		.in_stall (in_stall),
		.accept   (accept),
		.go       (go),
		.cw       (cw)
	);

	rcpfa_dp #(
		.FRAME_COUNT (FRAME_COUNT),
		.MEMORY_BASE (MEMORY_BASE),
		.IW          (IW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.go            (go),
		.cw            (cw),
		.action        (action),
		.entry         (entry),
		.mem_rdata     (mem_rdata),
		.out_stall     (out_stall),
		.st            (st),
		.mem_we        (dp_we),
		.mem_waddr     (dp_waddr),
		.mem_wdata     (dp_wdata),
		.mem_re        (mem_re),
		.mem_raddr     (mem_raddr),
		.out_valid     (out_valid),
		.result_word   (result_word),
		.copy_needed   (copy_needed),
		.out_of_frames (out_of_frames)
	);

	rcpfa_mem #(
		.FRAME_COUNT (FRAME_COUNT),
		.IW          (IW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
`default_nettype wire
